@@ design/fkmr_pkg.sv @@
`default_nettype none

package fkmr_pkg;

	// default table depth
	localparam int FlowSlotsDef = 16;

	// result status codes
	typedef enum logic [1:0] {
		STAT_PARTIAL  = 2'd0,
		STAT_COMPLETE = 2'd1,
		STAT_OVERRUN  = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	// slot update operations
	typedef enum logic [1:0] {
		UPD_CLAIM = 2'd0,
		UPD_ADD   = 2'd1,
		UPD_FREE  = 2'd2
	} upd_op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_HOLD = 2'd2
	} state_t;

	// normalised flow key
	typedef struct packed {
		logic        family;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [31:0] ports;
	} key_t;

	// search token walking down the row of cells
	typedef struct packed {
		logic        active;
		logic        hit;
		logic        free;
		logic [15:0] rc;
		logic [15:0] tot;
	} tok_t;

	// broadcast update to one slot
	typedef struct packed {
		logic        en;
		upd_op_t     op;
		logic [15:0] rc;
		logic [15:0] tot;
	} upd_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [3:0]  flow_slot;
		logic [15:0] offset;
		logic        new_flow;
	} res_t;

endpackage

`default_nettype wire

@@ design/fkmr_cell.sv @@
`default_nettype none

module fkmr_cell #(
	parameter int SLOT_W   = 4,
	parameter int CELL_IDX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire fkmr_pkg::key_t  key,
	input  wire fkmr_pkg::tok_t  tok_in,
	input  wire [SLOT_W-1:0]     hit_idx_in,
	input  wire [SLOT_W-1:0]     free_idx_in,
	output fkmr_pkg::tok_t       tok_out,
	output logic [SLOT_W-1:0]    hit_idx_out,
	output logic [SLOT_W-1:0]    free_idx_out,
	input  wire fkmr_pkg::upd_t  upd,
	input  wire [SLOT_W-1:0]     upd_idx
);
	import fkmr_pkg::*;

	localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(CELL_IDX);

	logic              valid_q;
	key_t              key_q;
	logic [15:0]       tot_q;
	logic [15:0]       rc_q;
	logic              match;
	logic              take_hit;
	logic              take_free;
	logic              act_q;
	logic              hit_q;
	logic              free_q;
	logic [15:0]       trc_q;
	logic [15:0]       ttot_q;
	logic [SLOT_W-1:0] hidx_q;
	logic [SLOT_W-1:0] fidx_q;

	// key compare against this slot
	assign match     = valid_q && (key_q == key);
	assign take_hit  = !tok_in.hit && match;
	assign take_free = !tok_in.free && !valid_q;

	// token control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_in.active;
		end
	end

	// token payload: first hit and first free slot win
	always_ff @(posedge clk) begin
		hit_q  <= tok_in.hit | match;
		free_q <= tok_in.free | !valid_q;
		if (take_hit) begin
			trc_q  <= rc_q;
			ttot_q <= tot_q;
			hidx_q <= MyIdx;
		end else begin
			trc_q  <= tok_in.rc;
			ttot_q <= tok_in.tot;
			hidx_q <= hit_idx_in;
		end
		fidx_q <= take_free ? MyIdx : free_idx_in;
	end

	assign tok_out      = '{active: act_q, hit: hit_q, free: free_q, rc: trc_q, tot: ttot_q};
	assign hit_idx_out  = hidx_q;
	assign free_idx_out = fidx_q;

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.en && upd_idx == MyIdx) begin
			case (upd.op)
				UPD_CLAIM: valid_q <= 1'b1;
				UPD_FREE:  valid_q <= 1'b0;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (upd.en && upd_idx == MyIdx) begin
			case (upd.op)
				UPD_CLAIM: begin
					key_q <= key;
					tot_q <= upd.tot;
					rc_q  <= upd.rc;
				end
				UPD_ADD: begin
					rc_q <= upd.rc;
				end
				default: begin
					rc_q <= rc_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/flow_keyed_message_reassembly_unit.sv @@
`default_nettype none
// channel | dir | tdata (low bit up)                          | tuser
// --------+-----+---------------------------------------------+----------------------
// s_      | in  | src_addr_hi, src_addr_lo, dst_addr_hi,      | is_ipv6
//         |     | dst_addr_lo, src_port, dst_port,            |
//         |     | segment_length, message_length              |
// m_      | out | flow_slot, write_offset, zero pad           | status, new_flow
//
// For each item a search token walks the row of slot cells one cell per cycle,
// then the result is decided and the slot updated.
// The output register lets the next item in while a result waits; a second
// finished result waits in a holding register until the first is taken.
// arst_n clears slot valid bits and all handshake state; no clearing pass.

module flow_keyed_message_reassembly_unit #(
	parameter int FLOW_SLOTS = fkmr_pkg::FlowSlotsDef
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [319:0] s_tdata,  // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
	                               // src_port, dst_port, segment_length, message_length
	input  wire  [0:0]   s_tuser,  // is_ipv6
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [23:0]  m_tdata,  // flow_slot, write_offset, 4 zero bits
	output logic [2:0]   m_tuser   // status, new_flow
);
	import fkmr_pkg::*;

	localparam int SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

	state_t            state_q;
	state_t            state_nx;
	key_t              key_q;
	key_t              key_in;
	logic [15:0]       seg_q;
	logic [15:0]       msg_q;
	logic              inject_q;
	logic              accept;
	logic              emerge;
	logic              load_new;
	logic              load_hold;
	tok_t              tok      [FLOW_SLOTS+1];
	logic [SLOT_W-1:0] hit_idx  [FLOW_SLOTS+1];
	logic [SLOT_W-1:0] free_idx [FLOW_SLOTS+1];
	upd_t              upd;
	logic [SLOT_W-1:0] upd_idx;
	res_t              res;
	res_t              res_q;
	res_t              out_q;
	logic              out_valid_q;
	logic [16:0]       sum;
	logic [SLOT_W+3:0] slot_ext;
	logic [SLOT_W-1:0] slot_sel;

	assign accept = s_tvalid && s_tready;

	// normalise the incoming key; IPv4 keeps only the low 32 address bits
	always_comb begin
		key_in.family = s_tuser[0];
		key_in.src_hi = s_tuser[0] ? s_tdata[63:0] : 64'd0;
		key_in.src_lo = s_tuser[0] ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
		key_in.dst_hi = s_tuser[0] ? s_tdata[191:128] : 64'd0;
		key_in.dst_lo = s_tuser[0] ? s_tdata[255:192] : {32'd0, s_tdata[223:192]};
		key_in.ports  = {s_tdata[271:256], s_tdata[287:272]};
	end

	// item register
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_in;
			seg_q <= s_tdata[303:288];
			msg_q <= s_tdata[319:304];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inject_q <= 1'b0;
		end else begin
			inject_q <= accept;
		end
	end

	// token enters the first cell once per item
	assign tok[0]      = '{active: inject_q, hit: 1'b0, free: 1'b0, rc: 16'd0, tot: 16'd0};
	assign hit_idx[0]  = '0;
	assign free_idx[0] = '0;

	// row of slot cells
	for (genvar i = 0; i < FLOW_SLOTS; i++) begin : g_cell
		fkmr_cell #(
			.SLOT_W   (SLOT_W),
			.CELL_IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.key          (key_q),
			.tok_in       (tok[i]),
			.hit_idx_in   (hit_idx[i]),
			.free_idx_in  (free_idx[i]),
			.tok_out      (tok[i+1]),
			.hit_idx_out  (hit_idx[i+1]),
			.free_idx_out (free_idx[i+1]),
			.upd          (upd),
			.upd_idx      (upd_idx)
		);
	end

	assign emerge = tok[FLOW_SLOTS].active;

	// decision on the finished search
	always_comb begin
		sum      = {1'b0, tok[FLOW_SLOTS].rc} + {1'b0, seg_q};
		slot_sel = tok[FLOW_SLOTS].free ? free_idx[FLOW_SLOTS] : '0;
		upd      = '{en: 1'b0, op: UPD_ADD, rc: 16'd0, tot: msg_q};
		upd_idx  = hit_idx[FLOW_SLOTS];
		res      = '{status: STAT_PARTIAL, flow_slot: 4'd0, offset: 16'd0, new_flow: 1'b0};
		if (tok[FLOW_SLOTS].hit) begin
			res.offset = tok[FLOW_SLOTS].rc;
			if (sum > {1'b0, tok[FLOW_SLOTS].tot}) begin
				res.status = STAT_OVERRUN;
			end else if (sum == {1'b0, tok[FLOW_SLOTS].tot}) begin
				res.status = STAT_COMPLETE;
				upd.en     = emerge;
				upd.op     = UPD_FREE;
			end else begin
				res.status = STAT_PARTIAL;
				upd.en     = emerge;
				upd.op     = UPD_ADD;
				upd.rc     = sum[15:0];
			end
		end else begin
			res.new_flow = 1'b1;
			upd_idx      = slot_sel;
			if (seg_q > msg_q) begin
				res.status = STAT_OVERRUN;
			end else if (seg_q == msg_q) begin
				res.status = STAT_COMPLETE;
			end else if (!tok[FLOW_SLOTS].free) begin
				res.status = STAT_FULL;
			end else begin
				res.status = STAT_PARTIAL;
				upd.en     = emerge;
				upd.op     = UPD_CLAIM;
				upd.rc     = seg_q;
			end
		end
		slot_ext      = {4'd0, tok[FLOW_SLOTS].hit ? hit_idx[FLOW_SLOTS] : slot_sel};
		res.flow_slot = slot_ext[3:0];
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_nx = ST_SCAN;
			ST_SCAN: if (emerge) state_nx = (out_valid_q && !m_tready) ? ST_HOLD : ST_IDLE;
			ST_HOLD: if (m_tready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// handshake outputs and loads
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		load_new  = (state_q == ST_SCAN) && emerge && (!out_valid_q || m_tready);
		load_hold = (state_q == ST_HOLD) && m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_new || load_hold) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result and holding registers
	always_ff @(posedge clk) begin
		if (emerge) begin
			res_q <= res;
		end
		if (load_new) begin
			out_q <= res;
		end else if (load_hold) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.offset, out_q.flow_slot};
	assign m_tuser  = {out_q.new_flow, out_q.status};

endmodule

`default_nettype wire

@@ design/fkmr_checker.sv @@
`default_nettype none

module fkmr_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tvalid,
	input wire         s_tready,
	input wire [319:0] s_tdata,
	input wire [0:0]   s_tuser,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [23:0]  m_tdata,
	input wire [2:0]   m_tuser
);
	import fkmr_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input item changed while waiting");

	// one item in flight: no accept straight after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken during search");

	// a full table reports slot 0, offset 0, new flow
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == STAT_FULL |-> m_tdata[19:0] == 20'd0 && m_tuser[2])
		else $error("table full result malformed");

	// a new flow always starts at offset 0
	a_new_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata[19:4] == 16'd0)
		else $error("new flow with non-zero offset");

endmodule

bind flow_keyed_message_reassembly_unit fkmr_checker u_fkmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import fkmr_pkg::*;

	localparam int Slots       = 16;
	localparam int PoolKeys    = 24;
	localparam int BatchItems  = 25;
	localparam int RandomItems = 1375;
	localparam int HoldCycles  = 300;
	localparam int StallLimit  = 4000;

	// one segment descriptor as the sender sees it
	typedef struct {
		logic        is_ipv6;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] seg_len;
		logic [15:0] msg_len;
	} segment_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [319:0] s_tdata  = '0;  // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
	                              // src_port, dst_port, segment_length, message_length
	logic [0:0]   s_tuser  = '0;  // is_ipv6
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [23:0]  m_tdata;        // flow_slot, write_offset, 4 zero bits
	logic [2:0]   m_tuser;        // status, new_flow

	flow_keyed_message_reassembly_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// predicted flow table
	logic        flow_valid [Slots];
	key_t        flow_key   [Slots];
	logic [15:0] flow_total [Slots];
	logic [15:0] flow_rcvd  [Slots];

	// sender side pool of flow keys and its rough view of open flows
	key_t pool      [PoolKeys];
	bit   pool_open [PoolKeys];
	int   pool_rem  [PoolKeys];

	segment_t seg_queue [$];
	segment_t cur_item;
	res_t     pending_results [$];

	int errors     = 0;
	int quiet      = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	bit hold_req   = 1'b0;
	bit calm       = 1'b0;
	bit s_took     = 1'b0;

	// normalised key: IPv4 ignores both high halves and the top of the low halves
	function automatic key_t flow_key_of(segment_t s);
		key_t k;
		k.family = s.is_ipv6;
		k.src_hi = s.is_ipv6 ? s.src_hi : 64'd0;
		k.src_lo = s.is_ipv6 ? s.src_lo : {32'd0, s.src_lo[31:0]};
		k.dst_hi = s.is_ipv6 ? s.dst_hi : 64'd0;
		k.dst_lo = s.is_ipv6 ? s.dst_lo : {32'd0, s.dst_lo[31:0]};
		k.ports  = {s.src_port, s.dst_port};
		return k;
	endfunction

	// lowest valid slot holding this key, or -1
	function automatic int find_flow(key_t k);
		for (int i = 0; i < Slots; i++)
			if (flow_valid[i] && flow_key[i] == k)
				return i;
		return -1;
	endfunction

	// one segment against the predicted table; updates the table
	function automatic res_t reassemble(segment_t s);
		key_t        k;
		int          hit;
		int          free_idx;
		logic [16:0] sum;
		res_t        r;
		k        = flow_key_of(s);
		hit      = find_flow(k);
		free_idx = -1;
		for (int i = Slots - 1; i >= 0; i--)
			if (!flow_valid[i])
				free_idx = i;
		if (hit >= 0) begin
			sum         = {1'b0, flow_rcvd[hit]} + {1'b0, s.seg_len};
			r.flow_slot = hit[3:0];
			r.offset    = flow_rcvd[hit];
			r.new_flow  = 1'b0;
			if (sum > {1'b0, flow_total[hit]}) begin
				r.status = STAT_OVERRUN;
			end else if (sum == {1'b0, flow_total[hit]}) begin
				r.status        = STAT_COMPLETE;
				flow_valid[hit] = 1'b0;
			end else begin
				r.status       = STAT_PARTIAL;
				flow_rcvd[hit] = sum[15:0];
			end
		end else begin
			r.new_flow  = 1'b1;
			r.offset    = 16'd0;
			r.flow_slot = free_idx >= 0 ? free_idx[3:0] : 4'd0;
			if (s.seg_len > s.msg_len) begin
				r.status = STAT_OVERRUN;
			end else if (s.seg_len == s.msg_len) begin
				r.status = STAT_COMPLETE;
			end else if (free_idx < 0) begin
				r.status = STAT_FULL;
			end else begin
				r.status             = STAT_PARTIAL;
				flow_valid[free_idx] = 1'b1;
				flow_key[free_idx]   = k;
				flow_total[free_idx] = s.msg_len;
				flow_rcvd[free_idx]  = s.seg_len;
			end
		end
		return r;
	endfunction

	// segment on a pool flow; IPv4 gets fresh junk in the ignored address bits
	function automatic segment_t make_segment(int k, int seg, int msg);
		segment_t s;
		s.is_ipv6  = pool[k].family;
		s.src_hi   = pool[k].src_hi;
		s.src_lo   = pool[k].src_lo;
		s.dst_hi   = pool[k].dst_hi;
		s.dst_lo   = pool[k].dst_lo;
		s.src_port = pool[k].ports[31:16];
		s.dst_port = pool[k].ports[15:0];
		s.seg_len  = seg[15:0];
		s.msg_len  = msg[15:0];
		if (!s.is_ipv6) begin
			s.src_hi        = {$urandom, $urandom};
			s.dst_hi        = {$urandom, $urandom};
			s.src_lo[63:32] = $urandom;
			s.dst_lo[63:32] = $urandom;
		end
		return s;
	endfunction

	task automatic note_fail(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	// every queued segment handed over, so the predicted table is current
	task automatic wait_sender_empty();
		while (seg_queue.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	// sender: new item only after the last one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_took) begin
			if (seg_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
				cur_item = seg_queue.pop_front();
				s_tdata  <= {cur_item.msg_len, cur_item.seg_len, cur_item.dst_port,
				             cur_item.src_port, cur_item.dst_lo, cur_item.dst_hi,
				             cur_item.src_lo, cur_item.src_hi};
				s_tuser  <= cur_item.is_ipv6;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(0, 99) >= 33;
		end
	end

	// prediction on accepted input, check on accepted output, stall watchdog
	always @(posedge clk) begin
		res_t want;
		bit   m_took;
		s_took = s_tvalid && s_tready;
		m_took = m_tvalid && m_tready;
		if (s_took)
			pending_results.push_back(reassemble(cur_item));
		if (m_took) begin
			if (pending_results.size() == 0) begin
				note_fail($sformatf("unexpected result: status %0d slot %0d offset %0d new %0b",
					m_tuser[1:0], m_tdata[3:0], m_tdata[19:4], m_tuser[2]));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[1:0] !== want.status || m_tdata[3:0] !== want.flow_slot ||
				    m_tdata[19:4] !== want.offset || m_tuser[2] !== want.new_flow)
					note_fail($sformatf({"mismatch: expected status %0d slot %0d offset %0d",
						" new %0b, got status %0d slot %0d offset %0d new %0b"},
						want.status, want.flow_slot, want.offset, want.new_flow,
						m_tuser[1:0], m_tdata[3:0], m_tdata[19:4], m_tuser[2]));
			end
		end
		if (arst_n) begin
			quiet = (s_took || m_took) ? 0 : quiet + 1;
			if (quiet >= StallLimit) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int       k;
		int       r;
		int       seg;
		int       msg;
		int       tot;
		int       rem;
		int       slot;
		segment_t s;
		for (int i = 0; i < Slots; i++)
			flow_valid[i] = 1'b0;

		// flow key pool, with a few extreme keys up front
		for (int i = 0; i < PoolKeys; i++) begin
			pool[i].family = 1'($urandom_range(0, 1));
			pool[i].src_hi = pool[i].family ? {$urandom, $urandom} : 64'd0;
			pool[i].src_lo = pool[i].family ? {$urandom, $urandom} : {32'd0, $urandom};
			pool[i].dst_hi = pool[i].family ? {$urandom, $urandom} : 64'd0;
			pool[i].dst_lo = pool[i].family ? {$urandom, $urandom} : {32'd0, $urandom};
			pool[i].ports  = $urandom;
			pool_open[i]   = 1'b0;
			pool_rem[i]    = 0;
		end
		pool[0] = '{family: 1'b1, src_hi: '1, src_lo: '1, dst_hi: '1, dst_lo: '1, ports: '1};
		pool[1].family = 1'b0;
		pool[1].src_hi = 64'd0;
		pool[1].dst_hi = 64'd0;
		pool[1].src_lo = {32'd0, 32'hffff_ffff};
		pool[1].dst_lo = {32'd0, $urandom};
		pool[2] = '{family: 1'b1, src_hi: '0, src_lo: '0, dst_hi: '0, dst_lo: '0, ports: '0};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty message, instant overrun, IPv4 junk bits, stored total,
		// overrun on an open flow, extreme lengths, then a full table
		seg_queue.push_back(make_segment(0, 0, 0));
		seg_queue.push_back(make_segment(0, 65535, 0));
		seg_queue.push_back(make_segment(1, 100, 300));
		seg_queue.push_back(make_segment(1, 0, 7));
		seg_queue.push_back(make_segment(1, 250, 0));
		seg_queue.push_back(make_segment(1, 200, 5));
		seg_queue.push_back(make_segment(2, 1, 65535));
		seg_queue.push_back(make_segment(2, 65534, 0));
		for (int i = 3; i < 3 + Slots; i++)
			seg_queue.push_back(make_segment(i, 10, 1000));
		seg_queue.push_back(make_segment(19, 10, 1000));
		seg_queue.push_back(make_segment(20, 5, 5));
		seg_queue.push_back(make_segment(21, 9, 3));

		// random: batches of mostly well-formed flows with some noise
		for (int b = 0; b * BatchItems < RandomItems; b++) begin
			wait_sender_empty();
			calm = (b >= 10 && b < 18);
			if (b == 25)
				hold_req = 1'b1;
			if (b == 40)
				while (pending_results.size() != 0)
					@(posedge clk);

			// resync the sender's view with the predicted table
			for (int i = 0; i < PoolKeys; i++) begin
				slot         = find_flow(pool[i]);
				pool_open[i] = slot >= 0;
				pool_rem[i]  = slot >= 0 ? int'(flow_total[slot]) - int'(flow_rcvd[slot]) : 0;
			end

			repeat (BatchItems) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					// unknown key that never gets stored
					s.is_ipv6  = 1'($urandom_range(0, 1));
					s.src_hi   = {$urandom, $urandom};
					s.src_lo   = {$urandom, $urandom};
					s.dst_hi   = {$urandom, $urandom};
					s.dst_lo   = {$urandom, $urandom};
					s.src_port = 16'($urandom);
					s.dst_port = 16'($urandom);
					s.msg_len  = 16'($urandom);
					s.seg_len  = 16'($urandom_range(int'(s.msg_len), 65535));
					seg_queue.push_back(s);
				end else begin
					k = $urandom_range(0, PoolKeys - 1);
					msg = $urandom_range(0, 65535);
					r = $urandom_range(0, 99);
					if (r < 14) begin
						// known key, arbitrary lengths
						seg = $urandom_range(0, 65535);
					end else if (pool_open[k]) begin
						rem = pool_rem[k];
						r = $urandom_range(0, 99);
						if (r < 60 && rem > 1) begin
							seg = $urandom_range(1, rem - 1 > 2000 ? 2000 : rem - 1);
							pool_rem[k] = rem - seg;
						end else if (r < 88) begin
							seg = rem;
							pool_open[k] = 1'b0;
						end else if (r < 95 && rem < 65535) begin
							seg = $urandom_range(rem + 1, rem + 1001 > 65535 ? 65535 : rem + 1001);
						end else begin
							seg = 0;
						end
					end else begin
						r = $urandom_range(0, 99);
						tot = r < 5 ? 65535 : r < 12 ? $urandom_range(1, 65535) :
						      $urandom_range(1, 4000);
						r = $urandom_range(0, 99);
						if (r < 75) begin
							seg = $urandom_range(0, (tot - 1) / 2);
							pool_open[k] = 1'b1;
							pool_rem[k]  = tot - seg;
						end else if (r < 88 || tot == 65535) begin
							seg = tot;
						end else begin
							seg = $urandom_range(tot + 1, 65535);
						end
						msg = tot;
					end
					seg_queue.push_back(make_segment(k, seg, msg));
				end
			end
		end

		// drain, then let the pipeline settle
		wait_sender_empty();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (Slots * 3) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0d results never arrived", pending_results.size());
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
design/fkmr_pkg.sv
design/fkmr_cell.sv
design/flow_keyed_message_reassembly_unit.sv
design/fkmr_checker.sv
bench/tb_top.sv
